// File: src/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, register codes and tap weight tables of the edge filter.
// ----------------------------------------------------------------------------
package edf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 3;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0]   MODE_RESET   = 3'd0;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam int                  MIN_DIM      = 9;

  // operator codes
  localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GRAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LAP_A = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LAP_B = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd5;

  // datapath widths
  localparam int ACC_W     = 16;
  localparam int WT_W      = 5;
  localparam int OFF_W     = 4;
  localparam int SQ_W      = 18;
  localparam int ROOT_W    = 9;
  localparam int BIT_W     = 4;
  localparam logic [7:0] SAT_MAX = 8'd255;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic signed [WT_W-1:0] WT_ZERO = 5'sd0;
  localparam logic signed [WT_W-1:0] WT_P1   = 5'sd1;
  localparam logic signed [WT_W-1:0] WT_N1   = -5'sd1;
  localparam logic signed [WT_W-1:0] WT_N2   = -5'sd2;
  localparam logic signed [WT_W-1:0] WT_P4   = 5'sd4;
  localparam logic signed [WT_W-1:0] WT_N4   = -5'sd4;
  localparam logic signed [WT_W-1:0] WT_N8   = -5'sd8;

  localparam logic signed [OFF_W-1:0] OFF_ZERO = 4'sd0;
  localparam logic signed [OFF_W-1:0] OFF_FAR  = 4'sd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       filler;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic signed [WT_W-1:0] w0;
    logic signed [WT_W-1:0] w1;
  } tap_wt_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] dy;
    logic signed [OFF_W-1:0] dx;
  } tap_off_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_SAT,
    ST_SQ0,
    ST_SQ1,
    ST_ROOT,
    ST_DONE
  } back_state_e;

  // weights of one tap of a 3x3 block, w1 only feeds the vertical gradient
  function automatic tap_wt_t tap_wt_f(logic [MODE_W-1:0] mode, logic [2:0] blk,
                                       logic [1:0] kr, logic [1:0] kc);
    tap_wt_t t;
    logic    centre;
    logic    left;
    logic    up;
    logic    corner;
    centre = (kr == 2'd1) && (kc == 2'd1);
    left   = (kr == 2'd1) && (kc == 2'd0);
    up     = (kr == 2'd0) && (kc == 2'd1);
    corner = (kr != 2'd1) && (kc != 2'd1);
    t.w0   = WT_ZERO;
    t.w1   = WT_ZERO;
    case (mode)
      MODE_LEFT: t.w0 = centre ? WT_P1 : (left ? WT_N1 : WT_ZERO);
      MODE_UP:   t.w0 = centre ? WT_P1 : (up ? WT_N1 : WT_ZERO);
      MODE_GRAD: begin
        t.w0 = centre ? WT_P1 : (left ? WT_N1 : WT_ZERO);
        t.w1 = centre ? WT_P1 : (up ? WT_N1 : WT_ZERO);
      end
      MODE_LAP_A: t.w0 = centre ? WT_P4 : (corner ? WT_P1 : WT_N2);
      MODE_LAP_B: t.w0 = centre ? WT_N8 : WT_P1;
      default:    t.w0 = (blk == 3'd0) ? WT_N4 : WT_P1;
    endcase
    return t;
  endfunction

  // centre of each 3x3 block of the block laplacian
  function automatic tap_off_t blk_off_f(logic [2:0] blk);
    tap_off_t o;
    o.dy = OFF_ZERO;
    o.dx = OFF_ZERO;
    case (blk)
      3'd1:    o.dy = -OFF_FAR;
      3'd2:    o.dy = OFF_FAR;
      3'd3:    o.dx = -OFF_FAR;
      3'd4:    o.dx = OFF_FAR;
      default: o.dy = OFF_ZERO;
    endcase
    return o;
  endfunction

endpackage

// File: src/edf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_queue
// Small register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module edf_queue import edf_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  logic [DW-1:0] slot_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: src/edf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_front
// Accepts pixel items, tracks frame position and classifies each item.
// ----------------------------------------------------------------------------
module edf_front import edf_pkg::*; #(
  parameter int WW = 11,
  parameter int HW = 13,
  parameter int NW = 23,
  parameter int AW = 14,
  parameter int EW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic [WW-1:0] w_i,
  input  logic [NW-1:0] total_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pix_in_t       in_item_i,
  input  logic          full_i,
  output logic          push_o,
  output logic [EW-1:0] entry_o
);

  typedef struct packed {
    logic          we;
    logic [7:0]    wdata;
    logic [AW-1:0] waddr;
    logic          due;
    logic          last;
    logic [HW-1:0] row;
    logic [WW-1:0] col;
    logic [AW-1:0] qaddr;
  } entry_t;

  logic [NW-1:0] n_q, n_d;
  logic [HW-1:0] r_q, r_d;
  logic [WW-1:0] c_q, c_d;
  logic [NW-1:0] lag, q;
  entry_t        ent;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign entry_o    = ent;

  // classify the item by its count in the frame
  always_comb begin
    lag       = NW'({w_i, 2'b00}) + NW'(3'd4);
    q         = n_q - lag;
    ent.we    = (n_q < total_i);
    ent.wdata = in_item_i.filler ? 8'd0 : in_item_i.pixel;
    ent.waddr = n_q[AW-1:0];
    ent.due   = (n_q >= lag);
    ent.last  = (q == total_i - NW'(1'b1));
    ent.row   = r_q;
    ent.col   = c_q;
    ent.qaddr = q[AW-1:0];
  end

  // frame position counters
  always_comb begin
    n_d = n_q;
    r_d = r_q;
    c_d = c_q;
    if (restart_i) begin
      n_d = '0;
      r_d = '0;
      c_d = '0;
    end else if (push_o) begin
      if (ent.due && ent.last) begin
        n_d = '0;
        r_d = '0;
        c_d = '0;
      end else begin
        n_d = n_q + 1'b1;
        if (ent.due) begin
          if (c_q == w_i - 1'b1) begin
            c_d = '0;
            r_d = r_q + 1'b1;
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      r_q <= '0;
      c_q <= '0;
    end else begin
      n_q <= n_d;
      r_q <= r_d;
      c_q <= c_d;
    end
  end

endmodule

// File: src/edf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_back
// Writes the line store, walks the operator taps and forms each result.
// ----------------------------------------------------------------------------
module edf_back import edf_pkg::*; #(
  parameter int WW = 11,
  parameter int HW = 13,
  parameter int AW = 14,
  parameter int EW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WW-1:0]     w_i,
  input  logic [HW-1:0]     h_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              empty_i,
  input  logic [EW-1:0]     entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_item_o
);

  typedef struct packed {
    logic          we;
    logic [7:0]    wdata;
    logic [AW-1:0] waddr;
    logic          due;
    logic          last;
    logic [HW-1:0] row;
    logic [WW-1:0] col;
    logic [AW-1:0] qaddr;
  } entry_t;

  entry_t ent;
  assign ent = entry_i;

  back_state_e state_q, state_d;

  logic [7:0]  mem [2**AW];
  logic [7:0]  rd_q;
  logic [AW-1:0] rd_addr;

  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] col_q, col_d;
  logic [AW-1:0] qaddr_q, qaddr_d;
  logic          last_q, last_d;
  logic [2:0]    blk_q, blk_d;
  logic [1:0]    kr_q, kr_d, kc_q, kc_d;
  logic          pend_q, inb_q, inb_d;
  tap_wt_t       wt_q, wt_d;
  logic signed [ACC_W-1:0] acc0_q, acc1_q;
  logic          acc_clr, tap_en;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [ROOT_W-1:0] root_q, root_d, trial;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [7:0]        res_q, res_d;
  logic              out_valid_q, out_valid_d;
  pix_out_t          out_q, out_d;

  logic              mem_we;
  logic [2:0]        last_blk;
  logic              border;
  tap_off_t          boff;
  logic signed [OFF_W-1:0] dy, dx;
  logic signed [AW:0]      dyw;
  logic signed [HW+1:0]    ty;
  logic signed [WW+1:0]    tx;
  logic signed [ACC_W-1:0] abs0;
  logic signed [13:0]      prod0, prod1;
  logic signed [SQ_W-1:0]  sqr;
  logic [2*ROOT_W-1:0]     tsq;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign mem_we      = pop_o && ent.we;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // line store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ent.waddr] <= ent.wdata;
    rd_q <= mem[rd_addr];
  end

  // tap position and address
  always_comb begin
    boff    = blk_off_f(blk_q);
    dy      = boff.dy + $signed({2'b00, kr_q}) - 4'sd1;
    dx      = boff.dx + $signed({2'b00, kc_q}) - 4'sd1;
    dyw     = $signed({{(AW+1-OFF_W){dy[OFF_W-1]}}, dy})
            * $signed({{(AW+1-WW){1'b0}}, w_i});
    rd_addr = qaddr_q + dyw[AW-1:0] + {{(AW-OFF_W){dx[OFF_W-1]}}, dx};
    ty      = $signed({2'b00, row_q}) + $signed({{(HW+2-OFF_W){dy[OFF_W-1]}}, dy});
    tx      = $signed({2'b00, col_q}) + $signed({{(WW+2-OFF_W){dx[OFF_W-1]}}, dx});
    inb_d   = !ty[HW+1] && (ty[HW:0] < {1'b0, h_i})
           && !tx[WW+1] && (tx[WW:0] < {1'b0, w_i});
    wt_d    = tap_wt_f(mode_i, blk_q, kr_q, kc_q);
  end

  // weighted tap products
  assign prod0 = wt_q.w0 * $signed({1'b0, rd_q});
  assign prod1 = wt_q.w1 * $signed({1'b0, rd_q});

  // helpers for the finishing steps
  always_comb begin
    last_blk = (mode_i >= MODE_BLOCK) ? 3'd4 : 3'd0;
    border   = (ent.row == '0) || (ent.col == '0)
            || (ent.row == h_i - 1'b1) || (ent.col == w_i - 1'b1);
    abs0     = acc0_q[ACC_W-1] ? -acc0_q : acc0_q;
    sqr      = $signed(acc0_q[8:0]) * $signed(acc0_q[8:0]);
    if (state_q == ST_SQ1) sqr = $signed(acc1_q[8:0]) * $signed(acc1_q[8:0]);
    trial    = root_q | (ROOT_W'(1) << bit_q);
    tsq      = trial * trial;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    qaddr_d     = qaddr_q;
    last_d      = last_q;
    blk_d       = blk_q;
    kr_d        = kr_q;
    kc_d        = kc_q;
    sq_d        = sq_q;
    root_d      = root_q;
    bit_d       = bit_q;
    res_d       = res_q;
    acc_clr     = 1'b0;
    tap_en      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          row_d   = ent.row;
          col_d   = ent.col;
          qaddr_d = ent.qaddr;
          last_d  = ent.last;
          if (ent.due) begin
            if (mode_i <= MODE_LAP_B && border) begin
              res_d   = SAT_MAX;
              state_d = ST_DONE;
            end else begin
              blk_d   = '0;
              kr_d    = '0;
              kc_d    = '0;
              acc_clr = 1'b1;
              state_d = ST_TAP;
            end
          end
        end
      end
      ST_TAP: begin
        tap_en = 1'b1;
        if (kc_q == 2'd2) begin
          kc_d = '0;
          if (kr_q == 2'd2) begin
            kr_d = '0;
            if (blk_q == last_blk) state_d = ST_DRAIN;
            else blk_d = blk_q + 1'b1;
          end else begin
            kr_d = kr_q + 1'b1;
          end
        end else begin
          kc_d = kc_q + 1'b1;
        end
      end
      ST_DRAIN: state_d = (mode_i == MODE_GRAD) ? ST_SQ0 : ST_SAT;
      ST_SAT: begin
        res_d   = (abs0 > ACC_W'(SAT_MAX)) ? SAT_MAX : abs0[7:0];
        state_d = ST_DONE;
      end
      ST_SQ0: begin
        sq_d    = sqr;
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        sq_d    = sq_q + sqr;
        root_d  = '0;
        bit_d   = BIT_W'(ROOT_W - 1);
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (tsq <= sq_q) root_d = trial;
        if (bit_q == '0) begin
          res_d   = (root_d > ROOT_W'(SAT_MAX)) ? SAT_MAX : root_d[7:0];
          state_d = ST_DONE;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.edge_value = res_q;
          out_d.frame_end  = last_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= tap_en;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    qaddr_q <= qaddr_d;
    last_q  <= last_d;
    blk_q   <= blk_d;
    kr_q    <= kr_d;
    kc_q    <= kc_d;
    inb_q   <= inb_d;
    wt_q    <= wt_d;
    sq_q    <= sq_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    res_q   <= res_d;
    out_q   <= out_d;
    if (acc_clr) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (pend_q && inb_q) begin
      acc0_q <= acc0_q + ACC_W'(prod0);
      acc1_q <= acc1_q + ACC_W'(prod1);
    end
  end

endmodule

// File: src/edge_difference_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_difference_filter
// Streaming 3x3 and 9x9 edge detector for 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_ready_o   in_item_i (pixel, filler)
//  out       out        out_valid_o / out_ready_i out_item_o (edge_value, frame_end)
//
//  An item that gives no result is popped while the back stays idle. A result
//  is paced by the single read port of the line store, one tap per cycle,
//  and mode 2 adds squaring and a bit-serial square root after the taps.
//  Border results in modes 0 to 4 skip the taps and give 255.
//  The line store needs no clearing after reset; the front keeps taking items
//  into its four-entry queue until it is full while the back or the output stalls.
// ----------------------------------------------------------------------------
module edge_difference_filter import edf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_item_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int AW = $clog2(8 * MAX_WIDTH + 16);
  localparam int EW = 1 + 8 + AW + 1 + 1 + HW + WW + AW;

  logic [MODE_W-1:0]   mode_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                restart;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic [NW-1:0]       total;
  logic                push, pop, full, empty;
  logic [EW-1:0]       q_in, q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  // clamp the frame size and form the pixel count
  always_comb begin
    if (width_q < WIDTH_W'(MIN_DIM))  w_eff = WW'(MIN_DIM);
    else if (width_q > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
    else                              w_eff = WW'(width_q);
    if (height_q < HEIGHT_W'(MIN_DIM)) h_eff = HW'(MIN_DIM);
    else if (height_q > MAX_HEIGHT)    h_eff = HW'(MAX_HEIGHT);
    else                               h_eff = HW'(height_q);
    total = NW'(NW'(w_eff) * NW'(h_eff));
  end

  edf_front #(.WW(WW), .HW(HW), .NW(NW), .AW(AW), .EW(EW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .w_i        (w_eff),
    .total_i    (total),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (q_in)
  );

  edf_queue #(.DW(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  edf_back #(.WW(WW), .HW(HW), .AW(AW), .EW(EW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_i         (w_eff),
    .h_i         (h_eff),
    .mode_i      (mode_q),
    .empty_i     (empty),
    .entry_i     (q_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
